/* hw/rtl/stmm_pkg.sv */
// Shared constants and types of the sparse triplet matrix multiply unit.
package stmm_pkg;

  localparam int MAX_TERMS    = 32;
  localparam int RESULT_TERMS = 64;
  localparam int MAX_DIM      = 255;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int DRN_W = $clog2(RESULT_TERMS + MAX_TERMS + 8);

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [1:0] ST_TERM  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic REG_B_COLUMNS = 1'b0;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
  } term_t;

  typedef struct packed {
    logic  valid;
    term_t t;
  } stok_t;

  typedef struct packed {
    logic               valid;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } ptok_t;

  typedef struct packed {
    logic               used;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [47:0] sum;
  } entry_t;

endpackage

/* hw/rtl/stmm_sort_cell.sv */
// One cell of the insertion sorter that orders B terms by column.
module stmm_sort_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  stmm_pkg::stok_t tok_in,
  output stmm_pkg::stok_t tok_out,
  output stmm_pkg::stok_t held
);
  import stmm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held.valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (tok_in.valid) begin
        if (!held.valid) begin
          held          <= tok_in;
          tok_out.valid <= 1'b0;
        end else if (tok_in.t.col < held.t.col) begin
          // smaller column takes the slot, equal ones pass on
          held    <= tok_in;
          tok_out <= held;
        end
      end
    end
  end

endmodule

/* hw/rtl/stmm_acc_cell.sv */
// One accumulator cell of the result chain.
module stmm_acc_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  stmm_pkg::ptok_t  tok_in,
  input  stmm_pkg::entry_t nxt,
  output stmm_pkg::ptok_t  tok_out,
  output stmm_pkg::entry_t ent
);
  import stmm_pkg::*;

  logic hit;
  assign hit = ent.used && (ent.row == tok_in.row) && (ent.col == tok_in.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.used      <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (shift) begin
      ent           <= nxt;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (tok_in.valid) begin
        if (hit) begin
          ent.sum       <= ent.sum + {{16{tok_in.value[31]}}, tok_in.value};
          tok_out.valid <= 1'b0;
        end else if (!ent.used) begin
          ent.used      <= 1'b1;
          ent.row       <= tok_in.row;
          ent.col       <= tok_in.col;
          ent.sum       <= {{16{tok_in.value[31]}}, tok_in.value};
          tok_out.valid <= 1'b0;
        end
      end
    end
  end

endmodule

/* hw/rtl/sparse_triplet_matrix_multiply_unit.sv */
// Top level of the sparse triplet matrix multiply unit.
// Usage:
//  - Input beats (in_valid/in_ready) carry a mode and one triplet. Mode 0
//    loads an A term, mode 1 a B term (one beat per cycle), mode 2 starts
//    the product, mode 3 is ignored. Terms beyond MAX_TERMS are dropped.
//  - A compute beat runs: B terms stream through an insertion-sort chain,
//    then every (A, sorted B) pair is issued once per cycle into a chain
//    of RESULT_TERMS accumulator cells, then the chain drains, then the
//    results shift out of the chain head, one cell per cycle unless a
//    stalled receiver holds them up.
//  - Results leave on out_valid/out_ready; last marks the final beat, an
//    empty product gives one beat with row/col/value 0, status ST_EMPTY/ST_OVF.
//  - in_ready is low from the compute beat until its final result sits in
//    the output register; a stalled receiver holds the output register and
//    the shift-out pauses.
//  - b_columns is written over the APB port at addresses 0 to 3 (reset 1).
//  - Synchronous reset empties all cells, counts and the overflow flag.
module sparse_triplet_matrix_multiply_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         term_row,
  input  logic [7:0]         term_col,
  input  logic signed [15:0] term_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic signed [47:0] out_value,
  output logic               last,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import stmm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SORT, S_SDRAIN, S_PROD, S_DRAIN, S_OUT} state_t;

  state_t     state;
  logic [7:0] b_columns;
  term_t      a_terms [MAX_TERMS];
  term_t      b_terms [MAX_TERMS];
  logic [CNT_W-1:0] a_count, b_count, nb, fi, pi, pj;
  logic [DRN_W-1:0] drn;
  logic       ovf;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_B_COLUMNS) ? {24'd0, b_columns} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) b_columns <= 8'd1;
    else if (psel && penable && pwrite && paddr[2] == REG_B_COLUMNS)
      b_columns <= pwdata[7:0];
  end

  assign in_ready = (state == S_IDLE);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // sorter chain
  stok_t s_tok [MAX_TERMS+1];
  stok_t srt   [MAX_TERMS];
  term_t fb;
  logic  fb_ok;
  assign fb    = b_terms[fi[IDX_W-1:0]];
  assign fb_ok = (fb.col >= 8'd1) && (fb.col <= b_columns) && (32'(fb.col) <= MAX_DIM);
  assign s_tok[0].valid = (state == S_SORT) && (fi < b_count) && fb_ok;
  assign s_tok[0].t     = fb;

  logic s_clear;
  assign s_clear = in_acc && (mode == MODE_COMPUTE);

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_sort
    stmm_sort_cell u_cell (
      .clk(clk), .rst(rst), .clear(s_clear),
      .tok_in(s_tok[g]), .tok_out(s_tok[g+1]), .held(srt[g])
    );
  end

  // pair issue, two stages
  term_t a_sel, b_sel, s1_a, s1_b;
  logic  s1_v;
  ptok_t ptok;
  assign a_sel = a_terms[pi[IDX_W-1:0]];
  assign b_sel = srt[pj[IDX_W-1:0]].t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v       <= 1'b0;
      ptok.valid <= 1'b0;
    end else begin
      s1_v       <= (state == S_PROD) && (b_sel.row == a_sel.col);
      ptok.valid <= s1_v;
    end
    s1_a       <= a_sel;
    s1_b       <= b_sel;
    ptok.row   <= s1_a.row;
    ptok.col   <= s1_b.col;
    ptok.value <= s1_a.value * s1_b.value;
  end

  // accumulator chain
  ptok_t  a_tok [RESULT_TERMS+1];
  entry_t ent   [RESULT_TERMS+1];
  logic   shift;
  assign a_tok[0]         = ptok;
  assign ent[RESULT_TERMS] = '0;

  for (genvar g = 0; g < RESULT_TERMS; g++) begin : g_acc
    stmm_acc_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .tok_in(a_tok[g]), .nxt(ent[g+1]), .tok_out(a_tok[g+1]), .ent(ent[g])
    );
  end

  // shift-out control: one pending nonzero entry is held back to know last
  entry_t pend;
  logic   pend_v, out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    shift = 1'b0;
    if (state == S_OUT && ent[0].used) begin
      if (ent[0].sum == 48'sd0 || !pend_v || out_free) shift = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      a_count   <= '0;
      b_count   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      fi        <= '0;
      nb        <= '0;
      pi        <= '0;
      pj        <= '0;
      drn       <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (a_tok[RESULT_TERMS].valid) ovf <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (mode == MODE_LOAD_A) begin
              if (a_count < CNT_W'(MAX_TERMS)) begin
                a_terms[a_count[IDX_W-1:0]] <= '{term_row, term_col, term_value};
                a_count <= a_count + 1'b1;
              end else ovf <= 1'b1;
            end else if (mode == MODE_LOAD_B) begin
              if (b_count < CNT_W'(MAX_TERMS)) begin
                b_terms[b_count[IDX_W-1:0]] <= '{term_row, term_col, term_value};
                b_count <= b_count + 1'b1;
              end else ovf <= 1'b1;
            end else if (mode == MODE_COMPUTE) begin
              fi    <= '0;
              nb    <= '0;
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (fi < b_count) begin
            if (fb_ok) nb <= nb + 1'b1;
            fi <= fi + 1'b1;
          end else begin
            drn   <= '0;
            state <= S_SDRAIN;
          end
        end
        S_SDRAIN: begin
          drn <= drn + 1'b1;
          if (drn == DRN_W'(MAX_TERMS + 1)) begin
            pi  <= '0;
            pj  <= '0;
            drn <= '0;
            state <= (a_count != '0 && nb != '0) ? S_PROD : S_DRAIN;
          end
        end
        S_PROD: begin
          if (pj + 1'b1 == nb) begin
            pj <= '0;
            pi <= pi + 1'b1;
            if (pi + 1'b1 == a_count) state <= S_DRAIN;
          end else pj <= pj + 1'b1;
        end
        S_DRAIN: begin
          drn <= drn + 1'b1;
          if (drn == DRN_W'(RESULT_TERMS + 4)) state <= S_OUT;
        end
        S_OUT: begin
          if (ent[0].used) begin
            if (ent[0].sum != 48'sd0) begin
              if (!pend_v) begin
                pend   <= ent[0];
                pend_v <= 1'b1;
              end else if (out_free) begin
                out_valid <= 1'b1;
                out_row   <= pend.row;
                out_col   <= pend.col;
                out_value <= pend.sum;
                last      <= 1'b0;
                status    <= ovf ? ST_OVF : ST_TERM;
                pend      <= ent[0];
              end
            end
          end else if (out_free) begin
            out_valid <= 1'b1;
            last      <= 1'b1;
            if (pend_v) begin
              out_row   <= pend.row;
              out_col   <= pend.col;
              out_value <= pend.sum;
              status    <= ovf ? ST_OVF : ST_TERM;
            end else begin
              out_row   <= 8'd0;
              out_col   <= 8'd0;
              out_value <= 48'sd0;
              status    <= ovf ? ST_OVF : ST_EMPTY;
            end
            pend_v  <= 1'b0;
            a_count <= '0;
            b_count <= '0;
            ovf     <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no product token may still be in flight once results shift out
  a_out_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !ptok.valid && !s1_v)
    else $error("product token in flight during shift-out");

  // the result chain head and the pending entry are empty whenever new items are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ent[0].used && !pend_v)
    else $error("result chain not empty in idle");

  // leaving shift-out puts the final beat up and clears the A count and overflow flag
  a_final: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !ent[0].used && out_free |=>
      out_valid && last && a_count == '0 && !ovf)
    else $error("final beat or clearing missing");

endmodule
